// ----- hdl/yhpi_pkg.sv -----
package yhpi_pkg;

  // Register map, word index (byte address = 4 * index)
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DB   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ILIM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OLIM = 3'd4;

  // Integral term scaling: 256 (Q8.8 gain) * 1e6 (us per s) = 2^14 * 15625
  localparam logic [28:0] DIV_CONST = 29'd256000000;
  localparam logic [56:0] DIV_ROUND = 57'd255999999;
  localparam logic [13:0] DIV_ODD   = 14'd15625;
  // floor(2^43 / 15625): estimate is at most one low for a 43-bit dividend
  localparam logic [29:0] RCP_M     = 30'd562949953;

  localparam logic signed [15:0] DRIVE_MAX = 16'sd32767;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_HOLD,
    OP_DBAND,
    OP_MULP,
    OP_SUMU,
    OP_MULI,
    OP_DIVINIT,
    OP_RCPLO,
    OP_RCPHI,
    OP_RCPMUL,
    OP_RCPFIX,
    OP_INTEG,
    OP_CLAMP,
    OP_ROUND,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_RELEASE,
    C_NO_INTEG
  } cond_t;

  typedef logic [3:0] pc_t;

  localparam pc_t S_IDLE    = 4'd0;
  localparam pc_t S_HOLD    = 4'd1;
  localparam pc_t S_DBAND   = 4'd2;
  localparam pc_t S_MULP    = 4'd3;
  localparam pc_t S_SUMU    = 4'd4;
  localparam pc_t S_MULI    = 4'd5;
  localparam pc_t S_DIVINIT = 4'd6;
  localparam pc_t S_RCPLO   = 4'd7;
  localparam pc_t S_RCPHI   = 4'd8;
  localparam pc_t S_RCPMUL  = 4'd9;
  localparam pc_t S_RCPFIX  = 4'd10;
  localparam pc_t S_INTEG   = 4'd11;
  localparam pc_t S_SUMU2   = 4'd12;
  localparam pc_t S_CLAMP   = 4'd13;
  localparam pc_t S_ROUND   = 4'd14;
  localparam pc_t S_EMIT    = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      S_IDLE:    w = '{op: OP_LOAD,    cond: C_NEXT,     target: S_IDLE};
      S_HOLD:    w = '{op: OP_HOLD,    cond: C_RELEASE,  target: S_EMIT};
      S_DBAND:   w = '{op: OP_DBAND,   cond: C_NEXT,     target: S_IDLE};
      S_MULP:    w = '{op: OP_MULP,    cond: C_NEXT,     target: S_IDLE};
      S_SUMU:    w = '{op: OP_SUMU,    cond: C_NEXT,     target: S_IDLE};
      S_MULI:    w = '{op: OP_MULI,    cond: C_NO_INTEG, target: S_CLAMP};
      S_DIVINIT: w = '{op: OP_DIVINIT, cond: C_NEXT,     target: S_IDLE};
      S_RCPLO:   w = '{op: OP_RCPLO,   cond: C_NEXT,     target: S_IDLE};
      S_RCPHI:   w = '{op: OP_RCPHI,   cond: C_NEXT,     target: S_IDLE};
      S_RCPMUL:  w = '{op: OP_RCPMUL,  cond: C_NEXT,     target: S_IDLE};
      S_RCPFIX:  w = '{op: OP_RCPFIX,  cond: C_NEXT,     target: S_IDLE};
      S_INTEG:   w = '{op: OP_INTEG,   cond: C_NEXT,     target: S_IDLE};
      S_SUMU2:   w = '{op: OP_SUMU,    cond: C_NEXT,     target: S_IDLE};
      S_CLAMP:   w = '{op: OP_CLAMP,   cond: C_NEXT,     target: S_IDLE};
      S_ROUND:   w = '{op: OP_ROUND,   cond: C_NEXT,     target: S_IDLE};
      S_EMIT:    w = '{op: OP_EMIT,    cond: C_ALWAYS,   target: S_IDLE};
      default:   w = '{op: OP_EMIT,    cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/yaw_hold_pi_controller_core.sv -----
// Yaw hold PI controller, microcoded: one control word per cycle, except while
// the sequencer waits at the load step for input or at the emit step for a
// stalled result to drain. A released hold skips to the emit step; when
// integration is gated off, the reciprocal-multiply divide for the integral term is skipped.
// A new input is taken only at the load step, after the last result is emitted.
// Synchronous active-high reset clears configuration registers, hold, integrator and valid.
module yaw_hold_pi_controller_core import yhpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               hold_enable,
  input  logic               rotation_requested,
  input  logic               moving,
  input  logic signed [23:0] yaw,
  input  logic        [15:0] elapsed_us,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] drive,
  output logic               hold_active,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic         [4:0] paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  // Configuration registers
  logic [15:0] kp, ki, db;
  logic [22:0] ilim, olim;

  // Sequencer
  pc_t             pc, pc_next;
  ucode_t          uw;
  logic            take, hold_pc;

  // Captured input
  logic               en_r, rot_r, mov_r;
  logic signed [23:0] yaw_r;
  logic        [15:0] dt_r;

  // Controller state
  logic               holding;
  logic signed [23:0] target;
  logic signed [24:0] integ;

  // Working registers
  logic signed [24:0] err;
  logic               e_neg;
  logic signed [33:0] p;
  logic signed [34:0] u;
  logic        [31:0] kidt;
  logic        [55:0] prod;
  logic        [42:0] dvy;
  logic        [51:0] acc;
  logic        [43:0] qd;
  logic        [29:0] dvq;
  logic signed [15:0] drive_res;
  logic               hold_res;

  // Combinational datapath
  logic               release_c;
  logic signed [23:0] tgt_eff;
  logic        [24:0] err_mag;
  logic signed [41:0] prod_p;
  logic        [34:0] u_mag;
  logic               integ_ok;
  logic        [56:0] dvd;
  logic        [43:0] rcp_rem;
  logic               rcp_up;
  logic signed [31:0] inc, isum, ilim_s;
  logic signed [34:0] olim_s;
  logic        [24:0] rsum;
  logic        [16:0] dmag;
  logic        [15:0] dmag16;

  // APB port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp   <= '0;
      ki   <= '0;
      db   <= '0;
      ilim <= '0;
      olim <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_KP:   kp   <= pwdata[15:0];
        REG_KI:   ki   <= pwdata[15:0];
        REG_DB:   db   <= pwdata[15:0];
        REG_ILIM: ilim <= pwdata[22:0];
        REG_OLIM: olim <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_KP:   prdata = {16'd0, kp};
      REG_KI:   prdata = {16'd0, ki};
      REG_DB:   prdata = {16'd0, db};
      REG_ILIM: prdata = {9'd0, ilim};
      REG_OLIM: prdata = {9'd0, olim};
      default:  prdata = '0;
    endcase
  end

  // Datapath terms
  assign release_c = !en_r || rot_r || !mov_r;
  assign tgt_eff   = holding ? target : yaw_r;
  assign err_mag   = err[24] ? 25'(-err) : 25'(err);
  assign prod_p    = 42'($signed({1'b0, kp})) * 42'(err);
  assign u_mag     = u[34] ? 35'(-u) : 35'(u);
  assign integ_ok  = u_mag < {12'd0, olim};
  assign dvd       = {1'b0, prod} + (e_neg ? DIV_ROUND : 57'd0);
  // remainder of the quotient estimate; one more divisor left means one low
  assign rcp_rem   = {1'b0, dvy} - qd;
  assign rcp_up    = rcp_rem >= {30'd0, DIV_ODD};
  assign inc       = e_neg ? -$signed({2'b00, dvq}) : $signed({2'b00, dvq});
  assign isum      = $signed({{7{integ[24]}}, integ}) + inc;
  assign ilim_s    = $signed({9'd0, ilim});
  assign olim_s    = $signed({12'd0, olim});
  assign rsum      = {1'b0, u_mag[23:0]} + 25'd128;
  assign dmag      = rsum[24:8];
  assign dmag16    = (dmag > 17'd32767) ? DRIVE_MAX : dmag[15:0];

  // Step sequencing
  assign uw       = ucode_rom(pc);
  assign in_stall = rst || (uw.op != OP_LOAD);
  assign hold_pc  = ((uw.op == OP_LOAD) && !in_valid) ||
                    ((uw.op == OP_EMIT) && out_valid && out_stall);

  always_comb begin
    unique case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_RELEASE:  take = release_c;
      C_NO_INTEG: take = !integ_ok;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (hold_pc) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_IDLE;
      holding   <= 1'b0;
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      // result stage: load on emit unless a stalled result is still waiting
      if ((uw.op == OP_EMIT) && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (uw.op)
        OP_HOLD: begin
          if (release_c) begin
            holding <= 1'b0;
            integ   <= '0;
          end else if (!holding) begin
            holding <= 1'b1;
            integ   <= '0;
          end
        end
        OP_INTEG: begin
          if (isum > ilim_s) begin
            integ <= ilim_s[24:0];
          end else if (isum < -ilim_s) begin
            integ <= 25'(-ilim_s);
          end else begin
            integ <= isum[24:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (in_valid) begin
          en_r  <= hold_enable;
          rot_r <= rotation_requested;
          mov_r <= moving;
          yaw_r <= yaw;
          dt_r  <= elapsed_us;
        end
      end
      OP_HOLD: begin
        if (release_c) begin
          drive_res <= '0;
          hold_res  <= 1'b0;
        end else begin
          if (!holding) begin
            target <= yaw_r;
          end
          err <= $signed({tgt_eff[23], tgt_eff}) - $signed({yaw_r[23], yaw_r});
        end
      end
      OP_DBAND: begin
        if (err_mag < {9'd0, db}) begin
          err <= '0;
        end
        kidt <= {16'd0, ki} * {16'd0, dt_r};
      end
      OP_MULP: p <= prod_p[41:8];
      OP_SUMU: u <= $signed({p[33], p}) + $signed({{10{integ[24]}}, integ});
      OP_MULI: begin
        prod  <= {24'd0, kidt} * {32'd0, err_mag[23:0]};
        e_neg <= err[24];
      end
      // divide by 2^14 * 15625: shift, then multiply by the reciprocal
      OP_DIVINIT: dvy <= dvd[56:14];
      OP_RCPLO:   acc <= {31'd0, dvy[20:0]} * {22'd0, RCP_M};
      OP_RCPHI:   acc <= {30'd0, dvy[42:21]} * {22'd0, RCP_M} + {22'd0, acc[50:21]};
      OP_RCPMUL: begin
        dvq <= acc[51:22];
        qd  <= {14'd0, acc[51:22]} * {30'd0, DIV_ODD};
      end
      OP_RCPFIX: begin
        if (rcp_up) begin
          dvq <= dvq + 30'd1;
        end
      end
      OP_CLAMP: begin
        if (u > olim_s) begin
          u <= olim_s;
        end else if (u < -olim_s) begin
          u <= -olim_s;
        end
      end
      OP_ROUND: begin
        drive_res <= u[34] ? -$signed(dmag16) : $signed(dmag16);
        hold_res  <= 1'b1;
      end
      OP_EMIT: begin
        if (!(out_valid && out_stall)) begin
          drive       <= drive_res;
          hold_active <= hold_res;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/yhpi_checker.sv -----
module yhpi_checker import yhpi_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] drive,
  input logic               hold_active
);

  // released hold always commands zero
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hold_active |-> drive == 16'sd0)
    else $error("nonzero drive without hold");

  // drive stays symmetric
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive >= -DRIVE_MAX)
    else $error("drive below negative limit");

  // one item at a time: busy right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // stalled result held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive) && $stable(hold_active))
    else $error("stalled result changed");

  // reset empties the output stage
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind yaw_hold_pi_controller_core yhpi_checker u_yhpi_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .drive       (drive),
  .hold_active (hold_active)
);
